### rtl/uhce_pkg.sv
// Package for the HID control endpoint: codes, stage type, descriptor ROM and result record.
// No dependencies.
package uhce_pkg;

	localparam int PacketBytes = 8;
	localparam int RomLen = 177;

	localparam logic [2:0] EV_SETUP = 3'd0;
	localparam logic [2:0] EV_OUT   = 3'd1;
	localparam logic [2:0] EV_IN    = 3'd2;
	localparam logic [2:0] EV_RESET = 3'd3;
	localparam logic [2:0] EV_STALL = 3'd4;

	localparam logic [1:0] IN_NONE   = 2'd0;
	localparam logic [1:0] IN_ARM    = 2'd1;
	localparam logic [1:0] IN_CANCEL = 2'd2;
	localparam logic [1:0] IN_STALL  = 2'd3;

	localparam logic [2:0] OUT_NONE   = 3'd0;
	localparam logic [2:0] OUT_CANCEL = 3'd1;
	localparam logic [2:0] OUT_ANY    = 3'd2;
	localparam logic [2:0] OUT_DATA1  = 3'd3;
	localparam logic [2:0] OUT_STALL  = 3'd4;

	localparam logic [1:0] DEV_DEFAULT    = 2'd1;
	localparam logic [1:0] DEV_ADDRESSED  = 2'd2;
	localparam logic [1:0] DEV_CONFIGURED = 2'd3;

	typedef enum logic [2:0] {
		STG_IDLE, STG_IN_DATA, STG_OUT_DATA, STG_STATUS_IN, STG_STATUS_OUT
	} stage_t;

	localparam logic [7:0] REG_VENDOR = 8'd0;
	localparam logic [7:0] REG_PRODUCT = 8'd1;

	localparam logic [7:0] DescRom [RomLen] = '{
		8'd18, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'd8, 8'hD8, 8'h04, 8'h3F, 8'h00,
		8'h00, 8'h01, 8'h01, 8'h02, 8'h00, 8'h01,
		8'd9, 8'h02, 8'd34, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'd50,
		8'd9, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00,
		8'd9, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'd63, 8'h00,
		8'd7, 8'h05, 8'h81, 8'h03, 8'd8, 8'h00, 8'd10,
		8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01, 8'h05, 8'h07, 8'h19, 8'hE0, 8'h29, 8'hE7,
		8'h15, 8'h00, 8'h25, 8'h01, 8'h75, 8'h01, 8'h95, 8'h08, 8'h81, 8'h02, 8'h95, 8'h01,
		8'h75, 8'h08, 8'h81, 8'h01, 8'h95, 8'h05, 8'h75, 8'h01, 8'h05, 8'h08, 8'h19, 8'h01,
		8'h29, 8'h05, 8'h91, 8'h02, 8'h95, 8'h01, 8'h75, 8'h03, 8'h91, 8'h01, 8'h95, 8'h06,
		8'h75, 8'h08, 8'h15, 8'h00, 8'h25, 8'h65, 8'h05, 8'h07, 8'h19, 8'h00, 8'h29, 8'h65,
		8'h81, 8'h00, 8'hC0,
		8'd4, 8'h03, 8'h09, 8'h04,
		8'd24, 8'h03, 8'h50, 8'h00, 8'h49, 8'h00, 8'h43, 8'h00, 8'h31, 8'h00, 8'h38, 8'h00,
		8'h46, 8'h00, 8'h34, 8'h00, 8'h36, 8'h00, 8'h4A, 8'h00, 8'h35, 8'h00, 8'h30, 8'h00,
		8'd34, 8'h03, 8'h50, 8'h00, 8'h49, 8'h00, 8'h43, 8'h00, 8'h20, 8'h00, 8'h48, 8'h00,
		8'h49, 8'h00, 8'h44, 8'h00, 8'h20, 8'h00, 8'h4B, 8'h00, 8'h65, 8'h00, 8'h79, 8'h00,
		8'h62, 8'h00, 8'h6F, 8'h00, 8'h61, 8'h00, 8'h72, 8'h00, 8'h64, 8'h00
	};

	typedef struct packed {
		logic [1:0]  in_action;
		logic [3:0]  in_length;
		logic [63:0] in_data;
		logic        in_toggle;
		logic [2:0]  out_action;
		logic        ep1_restart;
	} xfer_result_t;

endpackage

### rtl/uhce_chunk.sv
// Assembles one IN packet from the descriptor ROM or the reply bytes.
// Depends on uhce_pkg.
module uhce_chunk #(
	parameter int PACKET_BYTES = uhce_pkg::PacketBytes
) (
	input  logic        from_rom,
	input  logic [7:0]  offset,
	input  logic [3:0]  count,
	input  logic [63:0] reply,
	input  logic [15:0] vendor_id,
	input  logic [15:0] product_id,
	output logic [63:0] data
);

	always_comb begin
		logic [8:0] pos;
		logic [7:0] b;
		data = '0;
		for (int i = 0; i < PACKET_BYTES; i++) begin
			pos = {1'b0, offset} + 9'(i);
			b = 8'h00;
			if (from_rom) begin
				if (pos < 9'(uhce_pkg::RomLen)) begin
					case (pos)
						9'd8:    b = vendor_id[7:0];
						9'd9:    b = vendor_id[15:8];
						9'd10:   b = product_id[7:0];
						9'd11:   b = product_id[15:8];
						default: b = uhce_pkg::DescRom[pos[7:0]];
					endcase
				end
			end else if (pos < 9'd8) begin
				b = reply[pos[2:0]*8 +: 8];
			end
			if (4'(i) < count) data[i*8 +: 8] = b;
		end
	end

endmodule

### rtl/usb_hid_control_endpoint.sv
// Top level of the endpoint-0 control engine for a boot HID keyboard.
// Depends on uhce_pkg and uhce_chunk.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one endpoint-0 transaction
//   request: setup received, out done, in done, bus reset or stall handshaked,
//   with the setup bytes and the out packet's count and first byte.
//   The output channel (out_valid/out_ready) returns one result per request:
//   what to do with the endpoint 0 IN and OUT buffers, the armed IN packet,
//   and the device address, state, LED byte and endpoint 1 controls.
//   The result is registered and appears in the cycle after acceptance.
//   Throughput: one request per cycle while the receiver is ready; all decode
//   and the descriptor chunk are one combinational step between the state
//   registers and the result register.
//   A stalled receiver holds the result register; a new request is taken in
//   the same cycle the held result leaves, so ready = !out_valid | out_ready.
//   Reset: transfer idle, toggle DATA1, address 0, default state, LEDs off,
//   endpoint 1 disabled, vendor/product IDs to their defaults.
//   Configuration writes (vendor_id index 0, product_id index 1) are taken
//   at any edge with cfg_we high.
module usb_hid_control_endpoint #(
	parameter int PACKET_BYTES = uhce_pkg::PacketBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  event_kind,
	input  logic [63:0] setup_packet,
	input  logic [3:0]  out_count,
	input  logic [7:0]  out_first_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  in_action,
	output logic [3:0]  in_length,
	output logic [63:0] in_data,
	output logic        in_toggle,
	output logic [2:0]  out_action,
	output logic [6:0]  address_now,
	output logic [1:0]  state_now,
	output logic [7:0]  leds_now,
	output logic        ep1_enable,
	output logic        ep1_restart
);

	localparam logic [15:0] PktLen = 16'(PACKET_BYTES);

	logic [15:0] vendor_q, product_q;
	uhce_pkg::stage_t stage_q, stage_d;
	logic [7:0]  offset_q, offset_d;
	logic        rom_q, rom_d;
	logic [15:0] remain_q, remain_d;
	logic        zlp_q, zlp_d;
	logic        toggle_q, toggle_d;
	logic [6:0]  pend_q, pend_d, addr_q, addr_d;
	logic [1:0]  dstate_q, dstate_d;
	logic [7:0]  led_q, led_d;
	logic [63:0] reply_q, reply_d;
	logic        ep1_q, ep1_d;
	uhce_pkg::xfer_result_t res_d, res_q;

	logic        accept;
	logic        do_send;
	logic [3:0]  n;
	logic [63:0] chunk;

	assign in_ready = !out_valid || out_ready;
	assign accept = in_valid && in_ready;

	// next chunk size from whatever remaining/source the step lands on
	assign n = (remain_d > PktLen) ? 4'(PACKET_BYTES) : remain_d[3:0];

	uhce_chunk #(.PACKET_BYTES(PACKET_BYTES)) u_chunk (
		.from_rom(rom_d), .offset(offset_d), .count(n), .reply(reply_d),
		.vendor_id(vendor_q), .product_id(product_q), .data(chunk)
	);

	always_comb begin
		logic [7:0]  req, vl, vh;
		logic [6:0]  rtype;
		logic [15:0] wlen, len;
		logic        start, ackit, stall;
		stage_d = stage_q; offset_d = offset_q; rom_d = rom_q; remain_d = remain_q;
		zlp_d = zlp_q; toggle_d = toggle_q; pend_d = pend_q; addr_d = addr_q;
		dstate_d = dstate_q; led_d = led_q; reply_d = reply_q; ep1_d = ep1_q;
		res_d = '0; do_send = 1'b0;
		req = setup_packet[15:8]; vl = setup_packet[23:16]; vh = setup_packet[31:24];
		// request type field kept in place, as bits 6:5 of the first byte
		rtype = {setup_packet[6:5], 5'b0};
		wlen = setup_packet[63:48];
		len = '0; start = 1'b0; ackit = 1'b0; stall = 1'b0;
		case (event_kind)
			uhce_pkg::EV_SETUP: begin
				stage_d = uhce_pkg::STG_IDLE; remain_d = '0; offset_d = '0;
				zlp_d = 1'b0; toggle_d = 1'b1;
				res_d.in_action = uhce_pkg::IN_CANCEL;
				res_d.out_action = uhce_pkg::OUT_CANCEL;
				if (rtype == 7'h00) begin
					case (req)
						8'h06: begin
							rom_d = 1'b1; start = 1'b1;
							case (vh)
								8'h01: begin offset_d = 8'd0;  len = 16'd18; end
								8'h02: begin offset_d = 8'd18; len = 16'd34; end
								8'h21: begin offset_d = 8'd36; len = 16'd9;  end
								8'h22: begin offset_d = 8'd52; len = 16'd63; end
								8'h03: begin
									case (vl)
										8'd0: begin offset_d = 8'd115; len = 16'd4; end
										8'd1: begin offset_d = 8'd119; len = 16'd24; end
										8'd2: begin offset_d = 8'd143; len = 16'd34; end
										default: begin start = 1'b0; stall = 1'b1; rom_d = rom_q; end
									endcase
								end
								default: begin start = 1'b0; stall = 1'b1; rom_d = rom_q; end
							endcase
						end
						8'h05: begin pend_d = vl[6:0]; ackit = 1'b1; end
						8'h09: begin
							if (vl == 8'd0) begin
								dstate_d = uhce_pkg::DEV_ADDRESSED; ep1_d = 1'b0;
							end else begin
								ep1_d = 1'b1; res_d.ep1_restart = 1'b1;
								dstate_d = uhce_pkg::DEV_CONFIGURED;
							end
							ackit = 1'b1;
						end
						8'h08: begin
							reply_d = {63'd0, dstate_q == uhce_pkg::DEV_CONFIGURED};
							rom_d = 1'b0; start = 1'b1; len = 16'd1;
						end
						8'h00: begin reply_d = '0; rom_d = 1'b0; start = 1'b1; len = 16'd2; end
						8'h0A: begin reply_d = '0; rom_d = 1'b0; start = 1'b1; len = 16'd1; end
						8'h0B, 8'h01, 8'h03: ackit = 1'b1;
						default: stall = 1'b1;
					endcase
				end else if (rtype == 7'h20) begin
					case (req)
						8'h0A, 8'h0B: ackit = 1'b1;
						8'h02: begin reply_d = '0; rom_d = 1'b0; start = 1'b1; len = 16'd1; end
						8'h03: begin reply_d = 64'd1; rom_d = 1'b0; start = 1'b1; len = 16'd1; end
						8'h01: begin reply_d = '0; rom_d = 1'b0; start = 1'b1; len = 16'd8; end
						8'h09: begin
							if (wlen != 16'd0) begin
								stage_d = uhce_pkg::STG_OUT_DATA;
								res_d.out_action = uhce_pkg::OUT_DATA1;
							end else ackit = 1'b1;
						end
						default: stall = 1'b1;
					endcase
				end else stall = 1'b1;
				if (start) begin
					if (len > wlen) len = wlen;
					remain_d = len;
					zlp_d = (len < wlen) && (len != 16'd0) &&
						((len & (PktLen - 16'd1)) == 16'd0);
					stage_d = uhce_pkg::STG_IN_DATA;
					do_send = 1'b1;
				end
				if (ackit) begin
					stage_d = uhce_pkg::STG_STATUS_IN; remain_d = '0;
					res_d.in_action = uhce_pkg::IN_ARM; res_d.in_toggle = 1'b1;
				end
				if (stall) begin
					stage_d = uhce_pkg::STG_IDLE;
					res_d.in_action = uhce_pkg::IN_STALL;
					res_d.out_action = uhce_pkg::OUT_STALL;
				end
				if (stage_d == uhce_pkg::STG_IN_DATA || stage_d == uhce_pkg::STG_STATUS_IN)
					res_d.out_action = uhce_pkg::OUT_ANY;
			end
			uhce_pkg::EV_OUT: begin
				if (stage_q == uhce_pkg::STG_OUT_DATA) begin
					if (out_count != 4'd0) led_d = out_first_byte;
					stage_d = uhce_pkg::STG_STATUS_IN; remain_d = '0;
					res_d.in_action = uhce_pkg::IN_ARM; res_d.in_toggle = 1'b1;
				end else stage_d = uhce_pkg::STG_IDLE;
				res_d.out_action = uhce_pkg::OUT_ANY;
			end
			uhce_pkg::EV_IN: begin
				if (stage_q == uhce_pkg::STG_IN_DATA) begin
					if (remain_q != 16'd0) do_send = 1'b1;
					else if (zlp_q) begin zlp_d = 1'b0; do_send = 1'b1; end
					else stage_d = uhce_pkg::STG_STATUS_OUT;
				end else if (stage_q == uhce_pkg::STG_STATUS_IN) begin
					if (pend_q != 7'd0) begin
						addr_d = pend_q; dstate_d = uhce_pkg::DEV_ADDRESSED; pend_d = '0;
					end
					stage_d = uhce_pkg::STG_IDLE;
				end
			end
			uhce_pkg::EV_RESET: begin
				addr_d = '0; ep1_d = 1'b0; stage_d = uhce_pkg::STG_IDLE; pend_d = '0;
				led_d = '0; dstate_d = uhce_pkg::DEV_DEFAULT;
				res_d.in_action = uhce_pkg::IN_CANCEL;
				res_d.out_action = uhce_pkg::OUT_ANY;
				res_d.ep1_restart = 1'b1;
			end
			uhce_pkg::EV_STALL: begin
				if (stage_q == uhce_pkg::STG_IDLE) begin
					res_d.in_action = uhce_pkg::IN_CANCEL;
					res_d.out_action = uhce_pkg::OUT_ANY;
				end
			end
			default: ;
		endcase
		if (do_send) begin
			// ship the chunk and flip the toggle; the source advances below
			res_d.in_action = uhce_pkg::IN_ARM;
			res_d.in_length = n;
			res_d.in_data = chunk;
			res_d.in_toggle = toggle_d;
			toggle_d = !toggle_d;
		end
	end

	// the send adjusts offset/remaining after chunk assembly
	logic [7:0]  offset_n;
	logic [15:0] remain_n;
	assign offset_n = do_send ? offset_d + 8'(n) : offset_d;
	assign remain_n = do_send ? remain_d - 16'(n) : remain_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_q <= 16'h04D8; product_q <= 16'h003F;
			stage_q <= uhce_pkg::STG_IDLE; offset_q <= '0; rom_q <= 1'b0;
			remain_q <= '0; zlp_q <= 1'b0; toggle_q <= 1'b1; pend_q <= '0;
			addr_q <= '0; dstate_q <= uhce_pkg::DEV_DEFAULT; led_q <= '0;
			reply_q <= '0; ep1_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == uhce_pkg::REG_VENDOR) vendor_q <= cfg_data;
			if (cfg_we && cfg_index == uhce_pkg::REG_PRODUCT) product_q <= cfg_data;
			if (accept) begin
				stage_q <= stage_d; offset_q <= offset_n; rom_q <= rom_d;
				remain_q <= remain_n; zlp_q <= zlp_d; toggle_q <= toggle_d;
				pend_q <= pend_d; addr_q <= addr_d; dstate_q <= dstate_d;
				led_q <= led_d; reply_q <= reply_d; ep1_q <= ep1_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) res_q <= res_d;
	end

	assign in_action   = res_q.in_action;
	assign in_length   = res_q.in_length;
	assign in_data     = res_q.in_data;
	assign in_toggle   = res_q.in_toggle;
	assign out_action  = res_q.out_action;
	assign ep1_restart = res_q.ep1_restart;
	assign address_now = addr_q;
	assign state_now   = dstate_q;
	assign leds_now    = led_q;
	assign ep1_enable  = ep1_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_q))
		else $error("result changed while stalled");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_length <= 4'(PACKET_BYTES))
		else $error("packet too long");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_action != uhce_pkg::IN_ARM |-> in_length == 4'd0 && in_data == 64'd0)
		else $error("unarmed packet carries data");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_action == uhce_pkg::IN_STALL |-> stage_q == uhce_pkg::STG_IDLE)
		else $error("stall left a transfer open");

endmodule

### test/tb_usb_hid_control_endpoint.sv
// Self-checking testbench for usb_hid_control_endpoint: endpoint-0 control requests,
// descriptor chunking, toggles, deferred address, LED capture and ID registers.
// Depends on uhce_pkg and the RTL of usb_hid_control_endpoint.
module tb_usb_hid_control_endpoint;
	timeunit 1ns;
	timeprecision 1ps;
	import uhce_pkg::*;

	// Standard request codes
	localparam logic [7:0] STD_STATUS_RD     = 8'h00;
	localparam logic [7:0] STD_FEAT_CLR      = 8'h01;
	localparam logic [7:0] STD_FEAT_SET      = 8'h03;
	localparam logic [7:0] STD_ADDR_WR       = 8'h05;
	localparam logic [7:0] REQ_GET_DESC      = 8'h06;
	localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
	localparam logic [7:0] REQ_GET_IFACE     = 8'h0A;
	localparam logic [7:0] REQ_SET_IFACE     = 8'h0B;
	// HID class request codes
	localparam logic [7:0] CLS_REPORT_RD     = 8'h01;
	localparam logic [7:0] CLS_IDLE_RD       = 8'h02;
	localparam logic [7:0] CLS_PROTO_RD      = 8'h03;
	localparam logic [7:0] CLS_REPORT_WR     = 8'h09;
	localparam logic [7:0] CLS_IDLE_WR       = 8'h0A;
	localparam logic [7:0] CLS_PROTO_WR      = 8'h0B;
	localparam logic [7:0] REQ_BOGUS         = 8'hFF;
	// Descriptor types
	localparam logic [7:0] DT_DEVICE = 8'h01;
	localparam logic [7:0] DT_CONFIG = 8'h02;
	localparam logic [7:0] DT_STRING = 8'h03;
	localparam logic [7:0] DT_HID    = 8'h21;
	localparam logic [7:0] DT_REPORT = 8'h22;
	// bmRequestType type field, bits 6:5
	localparam logic [1:0] RT_STANDARD = 2'b00;
	localparam logic [1:0] RT_CLASS    = 2'b01;
	localparam logic [7:0] BM_DEV_IN   = 8'h80;
	localparam logic [7:0] BM_DEV_OUT  = 8'h00;
	localparam logic [7:0] BM_CLASS_IF = 8'h21;
	localparam logic [7:0] BM_CLASS_IN = 8'hA1;
	localparam logic [2:0] EV_UNDEF    = 3'd7;
	// Descriptor ROM offsets, and the total request count for the run
	localparam int OFS_DEV = 0, OFS_CFG = 18, OFS_HID = 36, OFS_REP = 52;
	localparam int OFS_STR0 = 115, OFS_STR1 = 119, OFS_STR2 = 143;
	localparam int ITEMS = 1950;

	typedef struct {
		logic [2:0]  kind;
		logic [63:0] sp;
		logic [3:0]  cnt;
		logic [7:0]  fb;
	} request_t;

	typedef struct {
		logic [1:0]  in_action;
		logic [3:0]  in_length;
		logic [63:0] in_data;
		logic        in_toggle;
		logic [2:0]  out_action;
		logic [6:0]  address;
		logic [1:0]  dev_state;
		logic [7:0]  leds;
		logic        ep1_en;
		logic        ep1_rst;
	} ep0_result_t;

	typedef struct {
		request_t   rq;
		bit         pin;
		logic [1:0] pin_in;
		logic [2:0] pin_out;
	} dir_row_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [7:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 0, out_ready = 0;
	logic [2:0] event_kind = '0;
	logic [63:0] setup_packet = '0;
	logic [3:0] out_count = '0;
	logic [7:0] out_first_byte = '0;
	logic in_ready, out_valid;
	logic [1:0] in_action;
	logic [3:0] in_length;
	logic [63:0] in_data;
	logic in_toggle;
	logic [2:0] out_action;
	logic [6:0] address_now;
	logic [1:0] state_now;
	logic [7:0] leds_now;
	logic ep1_enable, ep1_restart;

	usb_hid_control_endpoint u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.event_kind(event_kind), .setup_packet(setup_packet),
		.out_count(out_count), .out_first_byte(out_first_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.in_action(in_action), .in_length(in_length), .in_data(in_data),
		.in_toggle(in_toggle), .out_action(out_action),
		.address_now(address_now), .state_now(state_now), .leds_now(leds_now),
		.ep1_enable(ep1_enable), .ep1_restart(ep1_restart)
	);

	always #5 clk = ~clk;

	// Predictor copy of the control engine state
	stage_t      stage = STG_IDLE;
	logic [7:0]  src_ofs = '0;
	bit          src_rom = 0;
	logic [15:0] bytes_left = '0;
	bit          zlp_due = 0;
	logic        tog = 1'b1;
	logic [6:0]  addr_pending = '0, addr_cur = '0;
	logic [1:0]  dev_st = DEV_DEFAULT;
	logic [7:0]  led_byte = '0;
	logic [63:0] reply = '0;
	logic        ep1_on = 0;
	logic [15:0] vid = 16'h04D8, pid = 16'h003F;
	ep0_result_t nx;

	ep0_result_t expected_q[$];
	int n_sent = 0, n_fail = 0;
	bit calm = 0, hold_req = 0;

	function automatic logic [7:0] rom_at(int idx);
		if (idx >= RomLen) return 8'h00;
		if (idx == 8)  return vid[7:0];
		if (idx == 9)  return vid[15:8];
		if (idx == 10) return pid[7:0];
		if (idx == 11) return pid[15:8];
		return DescRom[idx];
	endfunction

	function automatic void next_chunk();
		int n, p;
		logic [63:0] d;
		n = bytes_left > PacketBytes ? PacketBytes : int'(bytes_left);
		d = '0;
		for (int i = 0; i < n; i++) begin
			p = int'(src_ofs) + i;
			d[8*i +: 8] = src_rom ? rom_at(p) : (p < 8 ? reply[8*p +: 8] : 8'h00);
		end
		src_ofs = src_ofs + 8'(n);
		bytes_left = bytes_left - 16'(n);
		nx.in_action = IN_ARM;
		nx.in_length = 4'(n);
		nx.in_data = d;
		nx.in_toggle = tog;
		tog = ~tog;
	endfunction

	function automatic void open_in(bit rom, int start, int len, int wlen);
		if (len > wlen) len = wlen;
		src_rom = rom;
		src_ofs = 8'(start);
		bytes_left = 16'(len);
		zlp_due = (len < wlen) && (len != 0) && (len % PacketBytes == 0);
		stage = STG_IN_DATA;
		next_chunk();
	endfunction

	function automatic void status_zlp();
		stage = STG_STATUS_IN;
		bytes_left = '0;
		nx.in_action = IN_ARM;
		nx.in_length = '0;
		nx.in_data = '0;
		nx.in_toggle = 1'b1;
	endfunction

	function automatic void decode_setup(logic [63:0] sp);
		logic [7:0] req, vl, vh;
		int wlen;
		req = sp[15:8];
		vl = sp[23:16];
		vh = sp[31:24];
		wlen = int'(sp[63:48]);
		stage = STG_IDLE;
		bytes_left = '0;
		src_ofs = '0;
		zlp_due = 0;
		tog = 1'b1;
		nx.in_action = IN_CANCEL;
		nx.out_action = OUT_CANCEL;
		if (sp[6:5] == RT_STANDARD) begin
			case (req)
				REQ_GET_DESC: begin
					case (vh)
						DT_DEVICE: begin open_in(1, OFS_DEV, 18, wlen); return; end
						DT_CONFIG: begin open_in(1, OFS_CFG, 34, wlen); return; end
						DT_HID:    begin open_in(1, OFS_HID, 9, wlen); return; end
						DT_REPORT: begin open_in(1, OFS_REP, 63, wlen); return; end
						DT_STRING: begin
							if (vl == 0) begin open_in(1, OFS_STR0, 4, wlen); return; end
							if (vl == 1) begin open_in(1, OFS_STR1, 24, wlen); return; end
							if (vl == 2) begin open_in(1, OFS_STR2, 34, wlen); return; end
						end
						default: ;
					endcase
				end
				STD_ADDR_WR: begin
					addr_pending = vl[6:0];
					status_zlp();
					return;
				end
				REQ_SET_CONFIG: begin
					if (vl == 0) begin
						dev_st = DEV_ADDRESSED;
						ep1_on = 0;
					end else begin
						ep1_on = 1;
						nx.ep1_rst = 1;
						dev_st = DEV_CONFIGURED;
					end
					status_zlp();
					return;
				end
				REQ_GET_CONFIG: begin
					reply = (dev_st == DEV_CONFIGURED) ? 64'd1 : 64'd0;
					open_in(0, 0, 1, wlen);
					return;
				end
				STD_STATUS_RD: begin reply = '0; open_in(0, 0, 2, wlen); return; end
				REQ_GET_IFACE:  begin reply = '0; open_in(0, 0, 1, wlen); return; end
				REQ_SET_IFACE, STD_FEAT_CLR, STD_FEAT_SET: begin
					status_zlp();
					return;
				end
				default: ;
			endcase
		end else if (sp[6:5] == RT_CLASS) begin
			case (req)
				CLS_IDLE_WR, CLS_PROTO_WR: begin status_zlp(); return; end
				CLS_IDLE_RD:     begin reply = '0; open_in(0, 0, 1, wlen); return; end
				CLS_PROTO_RD:    begin reply = 64'd1; open_in(0, 0, 1, wlen); return; end
				CLS_REPORT_RD:   begin reply = '0; open_in(0, 0, 8, wlen); return; end
				CLS_REPORT_WR: begin
					if (wlen != 0) begin
						stage = STG_OUT_DATA;
						nx.out_action = OUT_DATA1;
					end else begin
						status_zlp();
					end
					return;
				end
				default: ;
			endcase
		end
		// anything not decoded stalls both directions
		stage = STG_IDLE;
		nx.in_action = IN_STALL;
		nx.in_length = '0;
		nx.in_data = '0;
		nx.in_toggle = 0;
		nx.out_action = OUT_STALL;
	endfunction

	function automatic ep0_result_t predict_request(request_t rq);
		nx = '{default: '0};
		case (rq.kind)
			EV_SETUP: begin
				decode_setup(rq.sp);
				if (stage == STG_IN_DATA || stage == STG_STATUS_IN) nx.out_action = OUT_ANY;
			end
			EV_OUT: begin
				if (stage == STG_OUT_DATA) begin
					if (rq.cnt >= 1) led_byte = rq.fb;
					status_zlp();
				end else begin
					stage = STG_IDLE;
				end
				nx.out_action = OUT_ANY;
			end
			EV_IN: begin
				if (stage == STG_IN_DATA) begin
					if (bytes_left > 0) next_chunk();
					else if (zlp_due) begin
						zlp_due = 0;
						next_chunk();
					end else stage = STG_STATUS_OUT;
				end else if (stage == STG_STATUS_IN) begin
					// the new address takes effect only after the status stage
					if (addr_pending != 0) begin
						addr_cur = addr_pending;
						dev_st = DEV_ADDRESSED;
						addr_pending = '0;
					end
					stage = STG_IDLE;
				end
			end
			EV_RESET: begin
				addr_cur = '0;
				ep1_on = 0;
				nx.in_action = IN_CANCEL;
				nx.out_action = OUT_ANY;
				nx.ep1_rst = 1;
				stage = STG_IDLE;
				addr_pending = '0;
				led_byte = '0;
				dev_st = DEV_DEFAULT;
			end
			EV_STALL: begin
				if (stage == STG_IDLE) begin
					nx.in_action = IN_CANCEL;
					nx.out_action = OUT_ANY;
				end
			end
			default: ;
		endcase
		nx.address = addr_cur;
		nx.dev_state = dev_st;
		nx.leds = led_byte;
		nx.ep1_en = ep1_on;
		return nx;
	endfunction

	function automatic logic [63:0] setup_of(logic [7:0] bm, logic [7:0] req,
			logic [7:0] vl, logic [7:0] vh, logic [15:0] wlen);
		return {wlen, 16'($urandom), vh, vl, req, bm};
	endfunction

	// Mostly no gap, a few short ones and now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one request and hold it until the handshake; call right after a rising edge.
	task automatic offer(request_t rq, bit pin = 0, logic [1:0] pin_in = IN_NONE,
			logic [2:0] pin_out = OUT_NONE);
		int g;
		bit ok;
		ep0_result_t e;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		event_kind <= rq.kind;
		setup_packet <= rq.sp;
		out_count <= rq.cnt;
		out_first_byte <= rq.fb;
		// sample the handshake mid-cycle, where nothing is changing
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
		e = predict_request(rq);
		if (pin) begin
			e.in_action = pin_in;
			e.out_action = pin_out;
		end
		expected_q.push_back(e);
		n_sent++;
	endtask

	task automatic simple(logic [2:0] kind);
		request_t rq;
		rq.kind = kind;
		rq.sp = {$urandom, $urandom};
		rq.cnt = 4'($urandom_range(0, 15));
		rq.fb = 8'($urandom);
		offer(rq);
	endtask

	// Drop valid and wait for every expected result
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_VENDOR) vid = val;
		else if (idx == REG_PRODUCT) pid = val;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_wlen();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 16'($urandom_range(0, 70));
		if (r < 80) return 16'($urandom_range(0, 9) * 8);
		if (r < 95) return 16'($urandom);
		return 16'hFFFF;
	endfunction

	// One control transfer with random content, sometimes malformed, with rare noise mixed in
	task automatic random_transfer();
		request_t rq;
		logic [7:0] bm, req, vl, vh;
		int sel, guard;
		sel = $urandom_range(0, 99);
		vl = 8'($urandom_range(0, 2));
		vh = DT_DEVICE;
		bm = {$urandom_range(0, 1) ? 1'b1 : 1'b0, RT_STANDARD, 5'($urandom_range(0, 31))};
		if (sel < 40) begin
			req = REQ_GET_DESC;
			case ($urandom_range(0, 5))
				0: vh = DT_DEVICE;
				1: vh = DT_CONFIG;
				2: vh = DT_HID;
				3: vh = DT_REPORT;
				4: vh = DT_STRING;
				default: begin vh = 8'($urandom); vl = 8'($urandom); end
			endcase
		end else if (sel < 75) begin
			case ($urandom_range(0, 8))
				0: req = STD_STATUS_RD;
				1: req = STD_FEAT_CLR;
				2: req = STD_FEAT_SET;
				3: req = STD_ADDR_WR;
				4: req = REQ_GET_CONFIG;
				5: req = REQ_SET_CONFIG;
				6: req = REQ_GET_IFACE;
				7: req = REQ_SET_IFACE;
				default: req = 8'($urandom);
			endcase
			vl = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 1));
		end else if (sel < 95) begin
			bm = {1'($urandom), RT_CLASS, 5'($urandom)};
			case ($urandom_range(0, 6))
				0: req = CLS_REPORT_RD;
				1: req = CLS_IDLE_RD;
				2: req = CLS_PROTO_RD;
				3, 4: req = CLS_REPORT_WR;
				5: req = CLS_IDLE_WR;
				default: req = CLS_PROTO_WR;
			endcase
		end else begin
			// vendor or reserved type, or fully random bytes
			bm = {1'($urandom), 2'($urandom_range(2, 3)), 5'($urandom)};
			req = 8'($urandom);
		end
		rq.kind = EV_SETUP;
		rq.sp = setup_of(bm, req, vl, vh, pick_wlen());
		if (sel >= 98) rq.sp = {$urandom, $urandom};
		rq.cnt = 4'($urandom);
		rq.fb = 8'($urandom);
		offer(rq);
		guard = 0;
		while (stage != STG_IDLE && guard < 16) begin
			guard++;
			if ($urandom_range(0, 99) < 3) begin
				// noise: a stray event, an abandoned transfer or a bus reset
				simple(3'($urandom_range(1, 7)));
			end else if (stage == STG_IN_DATA || stage == STG_STATUS_IN) begin
				simple(EV_IN);
			end else begin
				// OUT data or status OUT
				simple(EV_OUT);
			end
		end
	endtask

	dir_row_t dir_rows[$];

	function automatic void row(logic [2:0] kind, logic [63:0] sp, logic [3:0] cnt,
			logic [7:0] fb, bit pin = 0, logic [1:0] pin_in = IN_NONE,
			logic [2:0] pin_out = OUT_NONE);
		dir_row_t r;
		r.rq = '{kind, sp, cnt, fb};
		r.pin = pin;
		r.pin_in = pin_in;
		r.pin_out = pin_out;
		dir_rows.push_back(r);
	endfunction

	// Receiver: mostly ready, short and long stalls, one long hold-off on request
	initial begin
		int r;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			r = $urandom_range(0, 99);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (80) @(posedge clk);
				hold_req = 0;
			end else if (!calm && r < 12) begin
				out_ready <= 1'b0;
				repeat (r < 10 ? $urandom_range(1, 3) : $urandom_range(10, 30)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Compare each result that leaves with the oldest expectation
	always @(negedge clk) begin
		ep0_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing expected");
				n_fail++;
			end else begin
				e = expected_q.pop_front();
				if (in_action !== e.in_action) begin
					$error("in_action expected %0d got %0d", e.in_action, in_action);
					n_fail++;
				end
				if (in_length !== e.in_length) begin
					$error("in_length expected %0d got %0d", e.in_length, in_length);
					n_fail++;
				end
				if (in_data !== e.in_data) begin
					$error("in_data expected %h got %h", e.in_data, in_data);
					n_fail++;
				end
				if (in_toggle !== e.in_toggle) begin
					$error("in_toggle expected %0d got %0d", e.in_toggle, in_toggle);
					n_fail++;
				end
				if (out_action !== e.out_action) begin
					$error("out_action expected %0d got %0d", e.out_action, out_action);
					n_fail++;
				end
				if (address_now !== e.address) begin
					$error("address_now expected %0d got %0d", e.address, address_now);
					n_fail++;
				end
				if (state_now !== e.dev_state) begin
					$error("state_now expected %0d got %0d", e.dev_state, state_now);
					n_fail++;
				end
				if (leds_now !== e.leds) begin
					$error("leds_now expected %h got %h", e.leds, leds_now);
					n_fail++;
				end
				if (ep1_enable !== e.ep1_en) begin
					$error("ep1_enable expected %0d got %0d", e.ep1_en, ep1_enable);
					n_fail++;
				end
				if (ep1_restart !== e.ep1_rst) begin
					$error("ep1_restart expected %0d got %0d", e.ep1_rst, ep1_restart);
					n_fail++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		logic [15:0] ph_vid [4], ph_pid [4];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: stall while idle, unknown event, descriptor chunks,
		// zero-length ending, unknown request, address masking, LED capture
		row(EV_STALL, '0, 0, 0, 1, IN_CANCEL, OUT_ANY);
		row(EV_UNDEF, '1, 4'hF, 8'hFF, 1, IN_NONE, OUT_NONE);
		row(EV_SETUP, setup_of(BM_DEV_IN, REQ_GET_DESC, 0, DT_DEVICE, 16'd64),
			0, 0, 1, IN_ARM, OUT_ANY);
		row(EV_IN, '0, 0, 0);
		row(EV_IN, '0, 0, 0);
		row(EV_IN, '0, 0, 0, 1, IN_NONE, OUT_NONE);
		row(EV_OUT, '0, 0, 0, 1, IN_NONE, OUT_ANY);
		row(EV_SETUP, setup_of(BM_DEV_IN, REQ_GET_DESC, 1, DT_STRING, 16'hFFFF), 0, 0);
		row(EV_IN, '0, 0, 0);
		row(EV_IN, '0, 0, 0);
		row(EV_IN, '0, 0, 0);
		row(EV_IN, '0, 0, 0);
		row(EV_SETUP, setup_of(BM_DEV_OUT, REQ_BOGUS, 0, 0, 0), 0, 0, 1, IN_STALL, OUT_STALL);
		row(EV_STALL, '0, 0, 0, 1, IN_CANCEL, OUT_ANY);
		row(EV_SETUP, setup_of(BM_DEV_OUT, STD_ADDR_WR, 8'hFF, 0, 0),
			0, 0, 1, IN_ARM, OUT_ANY);
		row(EV_IN, '0, 0, 0);
		row(EV_SETUP, setup_of(BM_DEV_OUT, STD_ADDR_WR, 8'h80, 0, 0), 0, 0);
		row(EV_IN, '0, 0, 0);
		row(EV_SETUP, setup_of(BM_DEV_OUT, REQ_SET_CONFIG, 1, 0, 0), 0, 0);
		row(EV_SETUP, setup_of(BM_CLASS_IF, CLS_REPORT_WR, 0, 2, 1),
			0, 0, 1, IN_CANCEL, OUT_DATA1);
		row(EV_OUT, '0, 4'hF, 8'hFF);
		row(EV_OUT, '0, 0, 0, 1, IN_NONE, OUT_ANY);
		row(EV_SETUP, setup_of(BM_CLASS_IN, CLS_REPORT_RD, 0, 1, 16'd8), 0, 0);
		row(EV_SETUP, setup_of(BM_DEV_IN, REQ_GET_DESC, 0, DT_DEVICE, 0), 0, 0);
		row(EV_RESET, '0, 0, 0, 1, IN_CANCEL, OUT_ANY);
		foreach (dir_rows[i])
			offer(dir_rows[i].rq, dir_rows[i].pin, dir_rows[i].pin_in, dir_rows[i].pin_out);

		// Random part in four phases, each with its own vendor and product IDs
		ph_vid = '{16'h04D8, 16'h0000, 16'hFFFF, 16'($urandom)};
		ph_pid = '{16'h003F, 16'h0000, 16'hFFFF, 16'($urandom)};
		for (int ph = 0; ph < 4; ph++) begin
			// pausing until everything has come back is also the idle point for writes
			drain();
			write_reg(REG_VENDOR, ph_vid[ph]);
			write_reg(REG_PRODUCT, ph_pid[ph]);
			calm = (ph == 1);
			if (ph == 2) hold_req = 1;
			while (n_sent < ITEMS * (ph + 1) / 4) begin
				random_transfer();
				if (calm && n_sent > ITEMS / 4 + 150) calm = 0;
			end
		end
		calm = 0;

		in_valid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
		repeat (5) @(posedge clk);
		if (n_fail == 0) $display("tb_usb_hid_control_endpoint OK");
		else $display("tb_usb_hid_control_endpoint NOT OK");
		$finish;
	end

	// Run limit, far beyond the slowest correct run
	initial begin
		#5ms;
		$display("tb_usb_hid_control_endpoint NOT OK");
		$finish;
	end

endmodule

### filelist.f
rtl/uhce_pkg.sv
rtl/uhce_chunk.sv
rtl/usb_hid_control_endpoint.sv
test/tb_usb_hid_control_endpoint.sv
